>>> hw/rtl/tbdb_pkg.sv
// types and constants shared by the button debounce bank and its parts
package tbdb_pkg;

    localparam int BTN_IN_W       = 7;
    localparam int LED_W          = 4;
    localparam int DISPLAY_BUTTON = 1;
    localparam int ENCODER_BUTTON = 6;

    localparam logic [2:0] DISPLAY_FIRST = 3'd0;
    localparam logic [2:0] DISPLAY_LAST  = 3'd4;

    localparam logic [1:0] BRIGHT_FULL = 2'd0;
    localparam logic [1:0] BRIGHT_MID  = 2'd1;
    localparam logic [1:0] BRIGHT_LOW  = 2'd2;
    localparam logic [1:0] BRIGHT_LAST = BRIGHT_LOW;

    localparam logic [7:0] BRIGHT_FULL_VAL = 8'd255;
    localparam logic [7:0] BRIGHT_MID_VAL  = 8'd140;
    localparam logic [7:0] BRIGHT_LOW_VAL  = 8'd70;

    localparam int          PADDR_W        = 3;
    localparam logic [2:0]  ADDR_DEBOUNCE  = 3'h0;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd50;

    typedef struct packed {
        logic [6:0]  buttons_low;
        logic [31:0] now_ms;
    } in_t;

    typedef struct packed {
        logic [6:0] pressed_flags;
        logic [3:0] led_drive;
        logic [2:0] display_index;
        logic       display_changed;
        logic [7:0] brightness_value;
        logic       brightness_changed;
    } out_t;

    typedef struct packed {
        logic pressed;
        logic press_evt;
    } lane_stat_t;

    function automatic logic [7:0] level_to_brightness(input logic [1:0] lvl);
        logic [7:0] val;
        case (lvl)
            BRIGHT_MID: val = BRIGHT_MID_VAL;
            BRIGHT_LOW: val = BRIGHT_LOW_VAL;
            default:    val = BRIGHT_FULL_VAL;
        endcase
        return val;
    endfunction

endpackage

>>> hw/rtl/tbdb_lane.sv
// debounce cell for one button: lockout timer compare and debounced state
module tbdb_lane (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   level,
    input  logic [31:0]            now_ms,
    input  logic [15:0]            debounce_ms,
    output tbdb_pkg::lane_stat_t   stat
);
    import tbdb_pkg::*;

    logic        state_reg;
    logic        state_next;
    logic [31:0] last_reg;
    logic [31:0] elapsed;
    logic        take;

    // wrapping difference, modulo 2^32
    assign elapsed    = now_ms - last_reg;
    assign take       = (level != state_reg) && (elapsed > {16'd0, debounce_ms});
    assign state_next = take ? level : state_reg;

    assign stat.pressed   = state_next;
    assign stat.press_evt = take && level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= 1'b0;
            last_reg  <= 32'd0;
        end else if (en && take) begin
            state_reg <= level;
            last_reg  <= now_ms;
        end
    end

endmodule

>>> hw/rtl/timed_button_debounce_bank_unit.sv
// top level of the timed button debounce bank
//
//  channel | ports             | direction | payload
//  --------+-------------------+-----------+-----------------------------
//  sample  | s_valid/s_ready   | in        | buttons_low, now_ms
//  result  | m_valid/m_ready   | out       | flags, leds, display, bright
//  config  | apb psel..pready  | in/out    | debounce_ms at address 0
//
// one item per clock sustained while results are taken; an item passes
// through the input register and then the result register around the
// per-button compare logic
// aresetn clears debounced states, change times and indexes and sets debounce_ms to 50
// a stalled result holds the pipe; an empty input register still takes one
// item while the result register waits to be taken
module timed_button_debounce_bank_unit #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tbdb_pkg::in_t                  s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tbdb_pkg::out_t                 m_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbdb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import tbdb_pkg::*;

    logic        in_valid_reg;
    in_t         in_reg;
    logic        out_valid_reg;
    out_t        out_reg;
    out_t        out_next;
    logic        advance;
    logic [15:0] debounce_reg;
    logic [2:0]  disp_reg;
    logic [2:0]  disp_next;
    logic [1:0]  bright_reg;
    logic [1:0]  bright_next;
    logic        disp_step;
    logic        bright_step;
    logic [6:0]  flags;

    logic [NUM_BUTTONS-1:0] lvl_in;
    lane_stat_t             stat [NUM_BUTTONS];

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_DEBOUNCE) ? {16'd0, debounce_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_DEBOUNCE) begin
            debounce_reg <= pwdata[15:0];
        end
    end

    // pipe control
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // per-button cells
    for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
        if (g < BTN_IN_W) begin : g_pin
            assign lvl_in[g] = in_reg.buttons_low[g];
        end else begin : g_nopin
            assign lvl_in[g] = 1'b0;
        end

        tbdb_lane u_lane (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .en          (advance),
            .level       (lvl_in[g]),
            .now_ms      (in_reg.now_ms),
            .debounce_ms (debounce_reg),
            .stat        (stat[g])
        );
    end

    for (genvar b = 0; b < BTN_IN_W; b++) begin : g_flag
        if (b < NUM_BUTTONS) begin : g_on
            assign flags[b] = stat[b].pressed;
        end else begin : g_off
            assign flags[b] = 1'b0;
        end
    end

    if (NUM_BUTTONS > DISPLAY_BUTTON) begin : g_disp
        assign disp_step = stat[DISPLAY_BUTTON].press_evt;
    end else begin : g_nodisp
        assign disp_step = 1'b0;
    end

    if (NUM_BUTTONS > ENCODER_BUTTON) begin : g_enc
        assign bright_step = stat[ENCODER_BUTTON].press_evt;
    end else begin : g_noenc
        assign bright_step = 1'b0;
    end

    always_comb begin
        disp_next = disp_reg;
        if (disp_step) begin
            disp_next = (disp_reg < DISPLAY_LAST) ? disp_reg + 3'd1 : DISPLAY_FIRST;
        end
        bright_next = bright_reg;
        if (bright_step) begin
            bright_next = (bright_reg < BRIGHT_LAST) ? bright_reg + 2'd1 : BRIGHT_FULL;
        end
    end

    always_comb begin
        out_next.pressed_flags      = flags;
        out_next.led_drive          = flags[LED_W-1:0];
        out_next.display_index      = disp_next;
        out_next.display_changed    = disp_step;
        out_next.brightness_value   = level_to_brightness(bright_next);
        out_next.brightness_changed = bright_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            disp_reg      <= DISPLAY_FIRST;
            bright_reg    <= BRIGHT_FULL;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                disp_reg      <= disp_next;
                bright_reg    <= bright_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

>>> hw/rtl/tbdb_checker.sv
// port-level checks on the debounce bank and the bind that attaches them
module tbdb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_valid,
    input logic                           m_ready,
    input tbdb_pkg::out_t                 m_data,
    input logic                           pready
);
    import tbdb_pkg::*;

    // a stalled result item holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    a_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.led_drive == m_data.pressed_flags[LED_W-1:0])
        else $error("led drive does not follow pressed flags");

    a_disp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.display_index <= DISPLAY_LAST)
        else $error("display index out of range");

    a_bright: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.brightness_value == BRIGHT_FULL_VAL
                  || m_data.brightness_value == BRIGHT_MID_VAL
                  || m_data.brightness_value == BRIGHT_LOW_VAL))
        else $error("brightness value not one of the three levels");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("config port not ready");

endmodule

bind timed_button_debounce_bank_unit tbdb_checker u_tbdb_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

>>> sim/tb_timed_button_debounce_bank_unit.sv
// testbench for the timed button debounce bank: directed table, random samples, scoreboard
`timescale 1ns / 1ps

module tb_timed_button_debounce_bank_unit;
    import tbdb_pkg::*;

    typedef enum bit {ROW_SAMPLE, ROW_WINDOW} plan_kind_t;

    typedef struct {
        plan_kind_t  kind;
        logic [6:0]  buttons;
        logic [31:0] stamp;
        logic [15:0] window;
        bit          typed;
        out_t        want;
    } plan_row_t;

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    in_t                 s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b1;
    out_t                m_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor copy of the debounce state
    logic [6:0]  held_state = '0;
    logic [31:0] change_stamp [BTN_IN_W] = '{default: '0};
    logic [2:0]  page_sel   = DISPLAY_FIRST;
    logic [1:0]  level_sel  = BRIGHT_FULL;
    logic [15:0] window_ms  = DEBOUNCE_RESET;

    out_t      pending_results [$];
    plan_row_t plan [$];
    int        fail_count   = 0;
    int        sample_count = 0;
    int        window_count = 0;
    int        page_steps   = 0;
    int        level_steps  = 0;
    int        ready_left   = 0;
    bit        quiet        = 1'b0;

    timed_button_debounce_bank_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 aclk = ~aclk;

    function automatic out_t debounce_sample(in_t smp);
        out_t        res;
        logic [31:0] gap;
        bit          page_step;
        bit          level_step;
        page_step  = 1'b0;
        level_step = 1'b0;
        for (int i = 0; i < BTN_IN_W; i++) begin
            if (smp.buttons_low[i] != held_state[i]) begin
                // wrapping elapsed time, must strictly exceed the window
                gap = smp.now_ms - change_stamp[i];
                if (gap > {16'h0, window_ms}) begin
                    change_stamp[i] = smp.now_ms;
                    held_state[i]   = smp.buttons_low[i];
                    if (smp.buttons_low[i] && i == DISPLAY_BUTTON) page_step = 1'b1;
                    if (smp.buttons_low[i] && i == ENCODER_BUTTON) level_step = 1'b1;
                end
            end
        end
        if (page_step)
            page_sel = (page_sel < DISPLAY_LAST) ? page_sel + 3'd1 : DISPLAY_FIRST;
        if (level_step)
            level_sel = (level_sel < BRIGHT_LAST) ? level_sel + 2'd1 : BRIGHT_FULL;
        page_steps  += int'(page_step);
        level_steps += int'(level_step);
        res.pressed_flags   = held_state;
        res.led_drive       = held_state[LED_W-1:0];
        res.display_index   = page_sel;
        res.display_changed = page_step;
        case (level_sel)
            BRIGHT_MID: res.brightness_value = BRIGHT_MID_VAL;
            BRIGHT_LOW: res.brightness_value = BRIGHT_LOW_VAL;
            default:    res.brightness_value = BRIGHT_FULL_VAL;
        endcase
        res.brightness_changed = level_step;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // valid stays high after acceptance; the caller either drives the next item or lowers it
    task automatic push_sample(in_t smp, bit typed, out_t want);
        out_t guess;
        s_valid <= 1'b1;
        s_data  <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        guess = debounce_sample(smp);
        pending_results.push_back(typed ? want : guess);
        sample_count++;
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_window(logic [15:0] w);
        wait_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DEBOUNCE;
        pwdata  <= {16'h0, w};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        check_field("debounce_ms", {16'h0, w}, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        window_ms = w;
        window_count++;
    endtask

    task automatic plan_sample(logic [6:0] b, logic [31:0] t, bit typed = 1'b0,
                               out_t want = '0);
        plan.push_back('{ROW_SAMPLE, b, t, 16'h0, typed, want});
    endtask

    task automatic plan_window(logic [15:0] w);
        plan.push_back('{ROW_WINDOW, 7'h0, 32'h0, w, 1'b0, out_t'('0)});
    endtask

    // result side stalls in bursts
    always @(posedge aclk) begin
        if (!aresetn || quiet) begin
            m_ready <= 1'b1;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (m_ready) begin
            if ($urandom_range(0, 9) == 0) begin
                m_ready    <= 1'b0;
                ready_left <= $urandom_range(1, 13) - 1;
            end
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 40);
        end
    end

    always @(posedge aclk) begin : watch_results
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result with none pending: %h", m_data);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("pressed_flags", 32'(want.pressed_flags),
                            32'(m_data.pressed_flags));
                check_field("led_drive", 32'(want.led_drive), 32'(m_data.led_drive));
                check_field("display_index", 32'(want.display_index),
                            32'(m_data.display_index));
                check_field("display_changed", 32'(want.display_changed),
                            32'(m_data.display_changed));
                check_field("brightness_value", 32'(want.brightness_value),
                            32'(m_data.brightness_value));
                check_field("brightness_changed", 32'(want.brightness_changed),
                            32'(m_data.brightness_changed));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        in_t         smp;
        logic [6:0]  pads;
        logic [31:0] clock_ms;
        logic [15:0] w;
        int          pick;
        int          hold_at;

        // early after reset nothing can change, then the window boundary
        plan_sample(7'h7f, 32'd10, 1'b1, out_t'{7'h00, 4'h0, 3'd0, 1'b0, 8'd255, 1'b0});
        plan_sample(7'h7f, 32'd51, 1'b1, out_t'{7'h7f, 4'hf, 3'd1, 1'b1, 8'd140, 1'b1});
        plan_sample(7'h00, 32'd60, 1'b1, out_t'{7'h7f, 4'hf, 3'd1, 1'b0, 8'd140, 1'b0});
        plan_sample(7'h00, 32'd101, 1'b1, out_t'{7'h7f, 4'hf, 3'd1, 1'b0, 8'd140, 1'b0});
        plan_sample(7'h00, 32'd102, 1'b1, out_t'{7'h00, 4'h0, 3'd1, 1'b0, 8'd140, 1'b0});
        // display and brightness both wrap
        for (int k = 0; k < 4; k++) begin
            plan_sample(7'h42, 32'd200 + 32'd200 * k);
            plan_sample(7'h00, 32'd300 + 32'd200 * k);
        end
        // time wrap
        plan_sample(7'h7f, 32'hffff_fff0);
        plan_sample(7'h00, 32'h0000_0010);
        plan_sample(7'h00, 32'h0000_0030);
        plan_sample(7'h55, 32'hffff_ffff);
        plan_sample(7'h2a, 32'h0000_0000);
        // zero window refuses a sample at the same millisecond
        plan_window(16'd0);
        plan_sample(7'h00, 32'd1000);
        plan_sample(7'h7f, 32'd1000);
        plan_sample(7'h7f, 32'd1001);
        plan_window(16'hffff);
        plan_sample(7'h00, 32'd66536);
        plan_sample(7'h00, 32'd66537);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].kind == ROW_WINDOW) begin
                write_window(plan[k].window);
            end else begin
                sender_gap();
                smp = '{buttons_low: plan[k].buttons, now_ms: plan[k].stamp};
                push_sample(smp, plan[k].typed, plan[k].want);
            end
        end

        pads     = 7'h00;
        clock_ms = 32'd70000;
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0:       w = 16'd0;
                1:       w = 16'hffff;
                2:       w = 16'($urandom_range(0, 255));
                3:       w = 16'($urandom());
                4:       w = 16'd1;
                5:       w = 16'($urandom_range(0, 100));
                6:       w = 16'($urandom_range(0, 65535));
                default: w = DEBOUNCE_RESET;
            endcase
            write_window(w);
            if (phase == 7) quiet = 1'b1;
            if (phase == 2) clock_ms = 32'hffff_f000;
            hold_at = $urandom_range(10, 160);
            for (int n = 0; n < 168; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    // same millisecond again
                end else if (pick < 12) begin
                    clock_ms = $urandom();
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, 2 * int'(w) + 3);
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    pads = pads ^ 7'(1 << $urandom_range(0, 6));
                else if (pick < 70)
                    pads = pads ^ 7'b100_0010;
                else if (pick < 80)
                    pads = 7'($urandom_range(0, 127));
                smp = '{buttons_low: pads, now_ms: clock_ms};
                sender_gap();
                push_sample(smp, 1'b0, '0);
                if (n == hold_at && !quiet) wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("ran %0d samples across %0d debounce settings, including time wrap",
                 sample_count, window_count);
        $display("saw %0d display steps and %0d brightness steps", page_steps, level_steps);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tbdb_pkg.sv
hw/rtl/tbdb_lane.sv
hw/rtl/timed_button_debounce_bank_unit.sv
hw/rtl/tbdb_checker.sv
sim/tb_timed_button_debounce_bank_unit.sv
